### rtl/bijective_bwt_block_encoder_top_assert.svh
// Assertion macros for the bijective BWT block encoder.
`ifndef BIJECTIVE_BWT_BLOCK_ENCODER_TOP_ASSERT_SVH
`define BIJECTIVE_BWT_BLOCK_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define BBWT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbwt assertion failed");
`define BBWT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbwt assertion failed");
`else
`define BBWT_ASSERT_IMP(lbl, ante, cons)
`define BBWT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/bbwt_pkg.sv
// Shared constants, command codes and status types of the BWT encoder.
package bbwt_pkg;
    localparam int BlockSizeDef = 64;
    localparam int OpW = 5;

    localparam logic [OpW-1:0] OP_NONE      = 5'd0;
    localparam logic [OpW-1:0] OP_LOAD      = 5'd1;
    localparam logic [OpW-1:0] OP_D_START   = 5'd2;
    localparam logic [OpW-1:0] OP_D_READ    = 5'd3;
    localparam logic [OpW-1:0] OP_D_STEP    = 5'd4;
    localparam logic [OpW-1:0] OP_D_SEG     = 5'd5;
    localparam logic [OpW-1:0] OP_D_FILL    = 5'd6;
    localparam logic [OpW-1:0] OP_S_INIT    = 5'd7;
    localparam logic [OpW-1:0] OP_S_OUTER   = 5'd8;
    localparam logic [OpW-1:0] OP_S_READKEY = 5'd9;
    localparam logic [OpW-1:0] OP_S_READPOS = 5'd10;
    localparam logic [OpW-1:0] OP_S_INFO    = 5'd11;
    localparam logic [OpW-1:0] OP_S_READB   = 5'd12;
    localparam logic [OpW-1:0] OP_S_ADV     = 5'd13;
    localparam logic [OpW-1:0] OP_S_SHIFT   = 5'd14;
    localparam logic [OpW-1:0] OP_S_PLACE   = 5'd15;
    localparam logic [OpW-1:0] OP_O_START   = 5'd16;
    localparam logic [OpW-1:0] OP_O_READSO  = 5'd17;
    localparam logic [OpW-1:0] OP_O_READPOS = 5'd18;
    localparam logic [OpW-1:0] OP_O_READB   = 5'd19;
    localparam logic [OpW-1:0] OP_O_EMIT    = 5'd20;

    typedef struct packed {
        logic [OpW-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic load_full;
        logic i_ge_n;
        logic j_lt_n;
        logic a_le_b;
        logic a_lt_b;
        logic a_ne_b;
        logic i_le_k;
        logic fill_last;
        logic j_zero;
        logic cnt_eq_lim;
        logic out_free;
        logic o_last;
    } stat_t;
endpackage

### rtl/bbwt_dp.sv
// Datapath: byte store, factor tables, sort order, counters and output register.
module bbwt_dp #(
    parameter int BLOCK_SIZE = bbwt_pkg::BlockSizeDef
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bbwt_pkg::cmd_t cmd,
    output bbwt_pkg::stat_t st,
    input  logic [7:0]    in_byte,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          out_last
);
    import bbwt_pkg::*;

    localparam int AW = $clog2(BLOCK_SIZE);
    localparam int CW = $clog2(BLOCK_SIZE + 1);
    localparam int LW = 2 * CW;

    logic [7:0]    byte_mem [BLOCK_SIZE];
    logic [AW-1:0] fs_mem   [BLOCK_SIZE];
    logic [CW-1:0] fl_mem   [BLOCK_SIZE];
    logic [AW-1:0] so_mem   [BLOCK_SIZE];

    logic [CW-1:0] n_reg, i_reg, j_reg, k_reg, p_reg, len_reg;
    logic [CW-1:0] la_reg, lb_reg, ra_reg, rb_reg;
    logic [AW-1:0] key_reg, sa_reg, sb_reg;
    logic [LW-1:0] cnt_reg, lim_reg;
    logic          out_valid_reg, out_last_reg;
    logic [7:0]    out_byte_reg;

    logic [7:0]    ba_q, bb_q;
    logic [AW-1:0] fsa_q, fsb_q, so_q;
    logic [CW-1:0] fla_q, flb_q;

    logic [AW-1:0] b_addr_a, b_addr_b, p_addr_a, p_addr_b, so_raddr, prev_pos;
    logic          b_ren, p_ren, so_ren;
    logic [CW-1:0] ra_inc, rb_inc;

    assign prev_pos = (key_reg == fsa_q) ? AW'(fsa_q + fla_q[AW-1:0] - 1'b1)
                                         : AW'(key_reg - 1'b1);
    assign ra_inc = CW'(ra_reg + 1'b1);
    assign rb_inc = CW'(rb_reg + 1'b1);

    always_comb
    begin
        b_ren = 1'b0;
        b_addr_a = '0;
        b_addr_b = '0;
        p_ren = 1'b0;
        p_addr_a = '0;
        p_addr_b = '0;
        so_ren = 1'b0;
        so_raddr = '0;
        case (cmd.op)
            OP_D_READ:
            begin
                b_ren = 1'b1;
                b_addr_a = k_reg[AW-1:0];
                b_addr_b = j_reg[AW-1:0];
            end
            OP_S_READB:
            begin
                b_ren = 1'b1;
                b_addr_a = AW'(sa_reg + ra_reg[AW-1:0]);
                b_addr_b = AW'(sb_reg + rb_reg[AW-1:0]);
            end
            OP_O_READB:
            begin
                b_ren = 1'b1;
                b_addr_a = prev_pos;
            end
            OP_S_READPOS:
            begin
                p_ren = 1'b1;
                p_addr_a = i_reg[AW-1:0];
                p_addr_b = so_q;
            end
            OP_O_READPOS:
            begin
                p_ren = 1'b1;
                p_addr_a = so_q;
            end
            OP_S_READKEY:
            begin
                so_ren = 1'b1;
                so_raddr = AW'(j_reg - 1'b1);
            end
            OP_O_READSO:
            begin
                so_ren = 1'b1;
                so_raddr = i_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            byte_mem[n_reg[AW-1:0]] <= in_byte;
        if (b_ren)
        begin
            ba_q <= byte_mem[b_addr_a];
            bb_q <= byte_mem[b_addr_b];
        end
        if (cmd.op == OP_D_FILL)
        begin
            fs_mem[p_reg[AW-1:0]] <= i_reg[AW-1:0];
            fl_mem[p_reg[AW-1:0]] <= len_reg;
        end
        if (p_ren)
        begin
            fsa_q <= fs_mem[p_addr_a];
            fla_q <= fl_mem[p_addr_a];
            fsb_q <= fs_mem[p_addr_b];
            flb_q <= fl_mem[p_addr_b];
        end
        if (cmd.op == OP_S_SHIFT)
            so_mem[j_reg[AW-1:0]] <= key_reg;
        else if (cmd.op == OP_S_PLACE)
            so_mem[j_reg[AW-1:0]] <= i_reg[AW-1:0];
        if (so_ren)
            so_q <= so_mem[so_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            p_reg <= '0;
            len_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_O_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op) inside
                OP_LOAD:
                begin
                    n_reg <= CW'(n_reg + 1'b1);
                    i_reg <= '0;
                end
                OP_D_START:
                begin
                    j_reg <= CW'(i_reg + 1'b1);
                    k_reg <= i_reg;
                end
                OP_D_STEP:
                begin
                    k_reg <= st.a_lt_b ? i_reg : CW'(k_reg + 1'b1);
                    j_reg <= CW'(j_reg + 1'b1);
                end
                OP_D_SEG:
                begin
                    p_reg <= i_reg;
                    len_reg <= CW'(j_reg - k_reg);
                end
                OP_D_FILL:
                begin
                    p_reg <= CW'(p_reg + 1'b1);
                    if (st.fill_last)
                        i_reg <= CW'(i_reg + len_reg);
                end
                OP_S_INIT, OP_O_START: i_reg <= '0;
                OP_S_OUTER: j_reg <= i_reg;
                OP_S_SHIFT: j_reg <= CW'(j_reg - 1'b1);
                OP_S_PLACE: i_reg <= CW'(i_reg + 1'b1);
                OP_O_EMIT:
                begin
                    i_reg <= CW'(i_reg + 1'b1);
                    if (st.o_last)
                        n_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            OP_S_READPOS, OP_O_READPOS: key_reg <= so_q;
            OP_S_INFO:
            begin
                sa_reg <= fsa_q;
                la_reg <= fla_q;
                sb_reg <= fsb_q;
                lb_reg <= flb_q;
                ra_reg <= CW'(i_reg - CW'(fsa_q));
                rb_reg <= CW'(CW'(key_reg) - CW'(fsb_q));
                cnt_reg <= '0;
                lim_reg <= LW'(LW'(fla_q) * LW'(flb_q));
            end
            OP_S_ADV:
            begin
                ra_reg <= (ra_inc == la_reg) ? '0 : ra_inc;
                rb_reg <= (rb_inc == lb_reg) ? '0 : rb_inc;
                cnt_reg <= LW'(cnt_reg + 1'b1);
            end
            OP_O_EMIT:
            begin
                out_byte_reg <= ba_q;
                out_last_reg <= st.o_last;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.load_full  = (n_reg == CW'(BLOCK_SIZE - 1));
        st.i_ge_n     = (i_reg >= n_reg);
        st.j_lt_n     = (j_reg < n_reg);
        st.a_le_b     = (ba_q <= bb_q);
        st.a_lt_b     = (ba_q < bb_q);
        st.a_ne_b     = (ba_q != bb_q);
        st.i_le_k     = (i_reg <= k_reg);
        st.fill_last  = (CW'(p_reg + 1'b1) == CW'(i_reg + len_reg));
        st.j_zero     = (j_reg == '0);
        st.cnt_eq_lim = (cnt_reg == lim_reg);
        st.out_free   = !out_valid_reg || out_ready;
        st.o_last     = (CW'(i_reg + 1'b1) == n_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
endmodule

### rtl/bbwt_ctrl.sv
// Controller: sequences loading, factorization, rotation sort and output.
module bbwt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    input  bbwt_pkg::stat_t st,
    output bbwt_pkg::cmd_t  cmd
);
    import bbwt_pkg::*;

    localparam logic [4:0] ST_LOAD    = 5'd0;
    localparam logic [4:0] ST_D_OUTER = 5'd1;
    localparam logic [4:0] ST_D_RD    = 5'd2;
    localparam logic [4:0] ST_D_CMP   = 5'd3;
    localparam logic [4:0] ST_D_SEG   = 5'd4;
    localparam logic [4:0] ST_D_FILL  = 5'd5;
    localparam logic [4:0] ST_S_OUTER = 5'd6;
    localparam logic [4:0] ST_S_CHK   = 5'd7;
    localparam logic [4:0] ST_S_KEY   = 5'd8;
    localparam logic [4:0] ST_S_INFO  = 5'd9;
    localparam logic [4:0] ST_S_RD    = 5'd10;
    localparam logic [4:0] ST_S_BCMP  = 5'd11;
    localparam logic [4:0] ST_S_SHIFT = 5'd12;
    localparam logic [4:0] ST_S_PLACE = 5'd13;
    localparam logic [4:0] ST_O_RDSO  = 5'd14;
    localparam logic [4:0] ST_O_RDPOS = 5'd15;
    localparam logic [4:0] ST_O_RDB   = 5'd16;
    localparam logic [4:0] ST_O_EMIT  = 5'd17;

    logic [4:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        unique case (state_reg)
            ST_LOAD:
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (in_last || st.load_full)
                        state_next = ST_D_OUTER;
                end
            ST_D_OUTER:
                if (st.i_ge_n)
                begin
                    cmd.op = OP_S_INIT;
                    state_next = ST_S_OUTER;
                end
                else
                begin
                    cmd.op = OP_D_START;
                    state_next = ST_D_RD;
                end
            ST_D_RD:
                if (st.j_lt_n)
                begin
                    cmd.op = OP_D_READ;
                    state_next = ST_D_CMP;
                end
                else
                    state_next = ST_D_SEG;
            ST_D_CMP:
                if (st.a_le_b)
                begin
                    cmd.op = OP_D_STEP;
                    state_next = ST_D_RD;
                end
                else
                    state_next = ST_D_SEG;
            ST_D_SEG:
                if (st.i_le_k)
                begin
                    cmd.op = OP_D_SEG;
                    state_next = ST_D_FILL;
                end
                else
                    state_next = ST_D_OUTER;
            ST_D_FILL:
            begin
                cmd.op = OP_D_FILL;
                if (st.fill_last)
                    state_next = ST_D_SEG;
            end
            ST_S_OUTER:
                if (st.i_ge_n)
                begin
                    cmd.op = OP_O_START;
                    state_next = ST_O_RDSO;
                end
                else
                begin
                    cmd.op = OP_S_OUTER;
                    state_next = ST_S_CHK;
                end
            ST_S_CHK:
                if (st.j_zero)
                    state_next = ST_S_PLACE;
                else
                begin
                    cmd.op = OP_S_READKEY;
                    state_next = ST_S_KEY;
                end
            ST_S_KEY:
            begin
                cmd.op = OP_S_READPOS;
                state_next = ST_S_INFO;
            end
            ST_S_INFO:
            begin
                cmd.op = OP_S_INFO;
                state_next = ST_S_RD;
            end
            ST_S_RD:
                if (st.cnt_eq_lim)
                    state_next = ST_S_PLACE;
                else
                begin
                    cmd.op = OP_S_READB;
                    state_next = ST_S_BCMP;
                end
            ST_S_BCMP:
                if (st.a_ne_b)
                    state_next = st.a_lt_b ? ST_S_SHIFT : ST_S_PLACE;
                else
                begin
                    cmd.op = OP_S_ADV;
                    state_next = ST_S_RD;
                end
            ST_S_SHIFT:
            begin
                cmd.op = OP_S_SHIFT;
                state_next = ST_S_CHK;
            end
            ST_S_PLACE:
            begin
                cmd.op = OP_S_PLACE;
                state_next = ST_S_OUTER;
            end
            ST_O_RDSO:
            begin
                cmd.op = OP_O_READSO;
                state_next = ST_O_RDPOS;
            end
            ST_O_RDPOS:
            begin
                cmd.op = OP_O_READPOS;
                state_next = ST_O_RDB;
            end
            ST_O_RDB:
            begin
                cmd.op = OP_O_READB;
                state_next = ST_O_EMIT;
            end
            ST_O_EMIT:
                if (st.out_free)
                begin
                    cmd.op = OP_O_EMIT;
                    state_next = st.o_last ? ST_LOAD : ST_O_RDSO;
                end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end
endmodule

### rtl/bijective_bwt_block_encoder_top.sv
// Top level of the bijective BWT block encoder.
// Usage:
//  - Input stream (s_*): one byte per request; s_tlast marks the last byte of
//    a block. A block also closes by itself when it reaches BLOCK_SIZE bytes.
//  - Output stream (m_*): one transformed byte per block byte, in sorted
//    rotation order; m_tlast flags the final byte of the block.
//  - Loading accepts one byte per cycle while s_tvalid is high. After the last
//    byte the block is factorized by Duval's algorithm, then rotations are
//    insertion-sorted: each rotation compare reads at most la*lb bytes, so a
//    block of n bytes takes on the order of n*n compares in the worst case.
//    Output runs one byte at a time through the chain of registered reads
//    (sort order, factor table, byte store).
//  - s_tready is high only while a block is loading; the block works on one
//    block at a time. The last result sits in the output register while the
//    next block starts loading.
//  - If the receiver stalls, the byte in the output register holds and the
//    sequencer waits; no result is lost.
//  - Reset clears the fill count and the sequencer; the memories are not
//    cleared and only entries written in the current block are read.
module bijective_bwt_block_encoder_top #(
    parameter int BLOCK_SIZE = bbwt_pkg::BlockSizeDef
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // block_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);
    import bbwt_pkg::*;

    cmd_t  cmd;
    stat_t st;

    bbwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bbwt_dp #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_byte   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

`include "bijective_bwt_block_encoder_top_assert.svh"

    // processing never overlaps with taking input
    `BBWT_ASSERT_IMP(a_no_input_while_busy, (cmd.op != OP_LOAD) && (cmd.op != OP_NONE), !s_tready)
    // a result is only loaded when the output register can take it
    `BBWT_ASSERT_IMP(a_emit_into_free_slot, cmd.op == OP_O_EMIT, st.out_free)
    // after the final result the block is ready for the next one
    `BBWT_ASSERT_NXT(a_ready_after_last, (cmd.op == OP_O_EMIT) && st.o_last, s_tready && m_tvalid)
endmodule

### bench/tb.sv
// Testbench for the bijective BWT block encoder: directed table plus random blocks.
`timescale 1ns / 100ps

module tb;

    localparam int BlkSize = 64;
    localparam int WatchLimit = 2000000;
    localparam int ItemCount = 120;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic       s_tlast;   // block_end
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;   // out_last

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } bwt_out_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       block_end;
        logic       has_exp;   // expected result typed in
        logic [7:0] exp_byte;
    } dir_row_t;

    bijective_bwt_block_encoder_top #(.BLOCK_SIZE(BlkSize)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state: the block being collected and its Lyndon factors.
    logic [7:0] blk_bytes[BlkSize];
    int         blk_fill;
    int         fac_first[BlkSize];
    int         fac_len[BlkSize];
    int         fac_of_pos[BlkSize];
    int         rot_order[BlkSize];

    bwt_out_t   bwt_expect_q[$];
    int         err_count;
    int         bytes_sent;
    int         blocks_sent;
    int         results_seen;
    int         quiet_cycles;
    int         recv_gap;
    logic       send_idle_en;
    logic       recv_idle_en;
    dir_row_t   dir_rows[$];

    // Appends one row to the directed table.
    function automatic void add_dir_row(logic [7:0] d, logic e, logic h, logic [7:0] x);
        dir_row_t row;
        begin
            row.data_byte = d;
            row.block_end = e;
            row.has_exp = h;
            row.exp_byte = x;
            dir_rows = {dir_rows, row};
        end
    endfunction

    // Duval split of the collected block.
    function automatic void lyndon_split(int n);
        int i, j, k, nf, p;
        begin
            i = 0;
            nf = 0;
            while (i < n)
            begin
                j = i + 1;
                k = i;
                while (j < n && blk_bytes[k] <= blk_bytes[j])
                begin
                    if (blk_bytes[k] < blk_bytes[j])
                        k = i;
                    else
                        k++;
                    j++;
                end
                while (i <= k)
                begin
                    fac_first[nf] = i;
                    fac_len[nf] = j - k;
                    for (p = i; p < i + (j - k); p++)
                        fac_of_pos[p] = nf;
                    nf++;
                    i += j - k;
                end
            end
        end
    endfunction

    // Omega order: true when rotation at a sorts strictly before rotation at b.
    function automatic logic omega_before(int a, int b);
        int sa, la, sb, lb, ra, rb, k;
        logic [7:0] ca, cb;
        begin
            sa = fac_first[fac_of_pos[a]];
            la = fac_len[fac_of_pos[a]];
            sb = fac_first[fac_of_pos[b]];
            lb = fac_len[fac_of_pos[b]];
            ra = a - sa;
            rb = b - sb;
            for (k = 0; k < la * lb; k++)
            begin
                ca = blk_bytes[sa + ra];
                cb = blk_bytes[sb + rb];
                if (ca != cb)
                    return ca < cb;
                ra = (ra + 1 == la) ? 0 : ra + 1;
                rb = (rb + 1 == lb) ? 0 : rb + 1;
            end
            return 1'b0;
        end
    endfunction

    // Adds one byte to the block; when the block closes, queues its transform.
    function automatic void bwt_accept_byte(logic [7:0] b, logic last);
        int i, j, n, p, s, prv;
        bwt_out_t r;
        begin
            blk_bytes[blk_fill] = b;
            blk_fill++;
            if (last || blk_fill >= BlkSize)
            begin
                n = blk_fill;
                lyndon_split(n);
                for (i = 0; i < n; i++)
                begin
                    j = i;
                    while (j > 0 && omega_before(i, rot_order[j-1]))
                    begin
                        rot_order[j] = rot_order[j-1];
                        j--;
                    end
                    rot_order[j] = i;
                end
                for (i = 0; i < n; i++)
                begin
                    p = rot_order[i];
                    s = fac_first[fac_of_pos[p]];
                    prv = (p == s) ? s + fac_len[fac_of_pos[p]] - 1 : p - 1;
                    r.out_byte = blk_bytes[prv];
                    r.out_last = (i + 1 == n);
                    bwt_expect_q = {bwt_expect_q, r};
                end
                blk_fill = 0;
                blocks_sent++;
            end
        end
    endfunction

    // Sends one request, with random idle bursts ahead of it.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        begin
            if (send_idle_en && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 10);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            s_tlast  <= last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            bwt_accept_byte(b, last);
            bytes_sent++;
        end
    endtask

    task automatic send_block(int n, int style);
        int i;
        logic [7:0] b;
        logic [7:0] base;
        begin
            base = 8'($urandom);
            for (i = 0; i < n; i++)
            begin
                case (style)
                    0: b = 8'($urandom);
                    1: b = 8'($urandom_range(0, 2) + base[1:0]); // small alphabet, many factors
                    2: b = base + i[7:0];                      // rising: one factor unless it wraps past FF
                    3: b = base - i[7:0];                      // falling: many one-byte factors
                    default: b = (i % 3 == 0) ? 8'hAA : 8'h55; // periodic, tied rotations
                endcase
                send_byte(b, i == n - 1);
            end
        end
    endtask

    // Output side: random stall bursts on m_tready, separated by ready cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (recv_idle_en && recv_gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (recv_idle_en && m_tready && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 9);
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        bwt_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (bwt_expect_q.size() == 0)
            begin
                $display("%0t: result expected none actual byte %02h last %0b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                want = bwt_expect_q.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.out_byte, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.out_last)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.out_last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no accepted request on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int i, n, style;
        bwt_out_t r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        blk_fill = 0;
        err_count = 0;
        bytes_sent = 0;
        blocks_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        // Directed table; single-byte blocks have a result readable at sight.
        add_dir_row(8'h00, 1'b1, 1'b1, 8'h00);
        add_dir_row(8'hFF, 1'b1, 1'b1, 8'hFF);
        add_dir_row(8'hA5, 1'b1, 1'b1, 8'hA5);
        add_dir_row(8'hFF, 1'b0, 1'b0, 8'h00);  // "ba": two factors
        add_dir_row(8'h00, 1'b1, 1'b0, 8'h00);
        add_dir_row(8'h00, 1'b0, 1'b0, 8'h00);  // "ab": one factor
        add_dir_row(8'hFF, 1'b1, 1'b0, 8'h00);
        add_dir_row(8'h5A, 1'b0, 1'b0, 8'h00);  // equal bytes tie
        add_dir_row(8'h5A, 1'b0, 1'b0, 8'h00);
        add_dir_row(8'h5A, 1'b1, 1'b0, 8'h00);
        add_dir_row(8'h01, 1'b0, 1'b0, 8'h00);  // "abab": repeated factor
        add_dir_row(8'h02, 1'b0, 1'b0, 8'h00);
        add_dir_row(8'h01, 1'b0, 1'b0, 8'h00);
        add_dir_row(8'h02, 1'b1, 1'b0, 8'h00);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].has_exp)
            begin
                // hand-written expectation replaces the predictor's for this row
                send_byte(dir_rows[i].data_byte, dir_rows[i].block_end);
                r = bwt_expect_q.pop_back();
                r.out_byte = dir_rows[i].exp_byte;
                r.out_last = 1'b1;
                bwt_expect_q = {bwt_expect_q, r};
            end
            else
            begin
                send_byte(dir_rows[i].data_byte, dir_rows[i].block_end);
            end
        end

        // Full store with block_end low closes the block by itself.
        for (i = 0; i < BlkSize; i++)
            send_byte(8'($urandom), 1'b0);

        // Hold off until every expected result has come back.
        s_tvalid <= 1'b0;
        while (bwt_expect_q.size() != 0)
            @(posedge clk);

        // Random blocks, mostly short.
        while (bytes_sent < ItemCount)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, BlkSize)
                                            : $urandom_range(1, 8);
            if (n > ItemCount - bytes_sent)
                n = ItemCount - bytes_sent;
            style = $urandom_range(0, 4);
            if (bytes_sent > ItemCount - 20)
            begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end
            send_block(n, style);
        end
        s_tvalid <= 1'b0;

        while (bwt_expect_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d bytes in %0d blocks, %0d result bytes checked",
                 bytes_sent, blocks_sent, results_seen);
        $display("single-byte, full-store, tied and multi-factor blocks with stalls");
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
